### hw/rtl/progress_stall_supervisor_macros.svh
// Assertion macros used by the checker file.
`ifndef PROGRESS_STALL_SUPERVISOR_MACROS_SVH
`define PROGRESS_STALL_SUPERVISOR_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define PSS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pss check failed");

// Next-cycle implication.
`define PSS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pss check failed");

`endif

### hw/rtl/pss_pkg.sv
// Types and constants of the progress stall supervisor.
package pss_pkg;

  localparam int unsigned DIR_FRAC_BITS = 14;
  localparam int unsigned SQRT_STEPS    = 32;
  localparam int unsigned MUL_STEPS     = 6;

  localparam logic [31:0] WINDOW_RST  = 32'd1000000;
  localparam logic [31:0] MIN_PROG_RST = 32'd65536;
  localparam logic [31:0] MIN_MOVE_RST = 32'd65536;
  localparam logic [7:0]  STALLS_RST  = 8'd2;

  typedef enum logic [2:0] {
    REG_ENABLED    = 3'd0,
    REG_WINDOW     = 3'd1,
    REG_MIN_PROG   = 3'd2,
    REG_MIN_MOVE   = 3'd3,
    REG_STALLS     = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    VERDICT_INACTIVE   = 2'd0,
    VERDICT_MONITORING = 2'd1,
    VERDICT_MOVING     = 2'd2,
    VERDICT_RESEED     = 2'd3
  } verdict_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_SQRT,
    ST_FIN
  } state_e;

endpackage

### hw/rtl/progress_stall_supervisor.sv
// Progress stall supervisor: top level with shared multiplier and square-root sequencer.
//
// Input channel (in_valid_i/in_ready_o) carries one timed observation per transfer;
// the output channel (out_valid_o/out_ready_i) returns exactly one result per input.
// The configuration channel (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i) is
// always ready; write it only while no observation is in flight.
// Each observation runs a fixed sequence: one 32x32 multiplier is reused for six
// products (three squared deltas, three tangent projections) and a drain step, then
// a restoring square root resolves one result bit per cycle, then a decision step
// decides the verdict and updates the anchor. A new observation is taken only once
// the decision step of the previous one has fired.
// A result waits in the output register while out_ready_i is low; the next
// observation can be taken in meanwhile, and its decision step holds until the
// output register is free.
// Reset loads the register defaults and drops the anchor, stall count, recovery
// and reseed count.
module progress_stall_supervisor (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               clear_i,
  input  logic [39:0]        stamp_us_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic               controller_on_i,
  input  logic [31:0]        route_gen_i,
  input  logic signed [31:0] station_i,
  input  logic signed [15:0] dir_x_i,
  input  logic signed [15:0] dir_y_i,
  input  logic signed [15:0] dir_z_i,
  input  logic               dir_valid_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         verdict_o,
  output logic               reseed_request_o,
  output logic               in_recovery_o,
  output logic [7:0]         stall_count_o,
  output logic [31:0]        reseed_count_o,
  output logic [39:0]        age_us_o,
  output logic [31:0]        displacement_o,
  output logic               route_used_o,
  output logic [31:0]        station_gain_o,
  output logic [31:0]        along_gain_o,
  output logic [31:0]        useful_gain_o
);

  localparam logic [31:0] M32 = 32'hFFFF_FFFF;

  // configuration
  logic        enabled_q;
  logic [31:0] window_q, min_prog_q, min_move_q;
  logic [7:0]  sbr_q;

  // sequencer
  pss_pkg::state_e state_q, state_d;
  logic [4:0] step_q;
  logic       accept, fin_fire;

  // latched observation
  logic               clr_q, ctl_q, dirv_q;
  logic [39:0]        stamp_q;
  logic signed [31:0] pos_q [3];
  logic [31:0]        gen_q;
  logic signed [31:0] st_q;
  logic signed [15:0] dir_q [3];

  // anchor and supervisor state
  logic               av_q, ast_ok_q, adir_ok_q, recov_q;
  logic [39:0]        at_q;
  logic signed [31:0] apos_q [3];
  logic [31:0]        agen_q;
  logic signed [31:0] ast_q;
  logic signed [15:0] adir_q [3];
  logic [7:0]         stalls_q;
  logic [31:0]        reseeds_q;

  // arithmetic
  logic [31:0] dabs [3];
  logic        dneg [3];
  logic [15:0] dirabs [3];
  logic        dirneg [3];
  logic [1:0]  idx;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod_q;
  logic        pvalid_q, pdot_q, pneg_q;
  logic [65:0] sum_q;
  logic signed [51:0] dot_q;
  logic [63:0] n_q, r_q, bit_q, sq_t;

  // output register
  logic        out_valid_q;
  logic [1:0]  verdict_q;
  logic        req_q, rec_q, used_q;
  logic [7:0]  ostall_q;
  logic [31:0] oreseed_q, disp_q, sgain_q, along_q, useful_q;
  logic [39:0] age_q;

  assign cfg_ready_o = 1'b1;
  assign accept   = in_valid_i && in_ready_o;
  assign fin_fire = (state_q == pss_pkg::ST_FIN) && (!out_valid_q || out_ready_i);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pss_pkg::ST_IDLE: if (accept) state_d = pss_pkg::ST_MUL;
      pss_pkg::ST_MUL:  if (step_q == 5'(pss_pkg::MUL_STEPS)) state_d = pss_pkg::ST_SQRT;
      pss_pkg::ST_SQRT: if (step_q == 5'(pss_pkg::SQRT_STEPS - 1)) state_d = pss_pkg::ST_FIN;
      pss_pkg::ST_FIN:  if (fin_fire) state_d = pss_pkg::ST_IDLE;
      default:          state_d = pss_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o = 1'b0;
    case (state_q)
      pss_pkg::ST_IDLE: in_ready_o = 1'b1;
      default:          in_ready_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pss_pkg::ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q != state_d) step_q <= '0;
      else step_q <= step_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q  <= 1'b1;
      window_q   <= pss_pkg::WINDOW_RST;
      min_prog_q <= pss_pkg::MIN_PROG_RST;
      min_move_q <= pss_pkg::MIN_MOVE_RST;
      sbr_q      <= pss_pkg::STALLS_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pss_pkg::REG_ENABLED:  enabled_q  <= cfg_data_i[0];
        pss_pkg::REG_WINDOW:   window_q   <= cfg_data_i;
        pss_pkg::REG_MIN_PROG: min_prog_q <= cfg_data_i;
        pss_pkg::REG_MIN_MOVE: min_move_q <= cfg_data_i;
        pss_pkg::REG_STALLS:   sbr_q      <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      clr_q    <= clear_i;
      stamp_q  <= stamp_us_i;
      pos_q[0] <= pos_x_i;
      pos_q[1] <= pos_y_i;
      pos_q[2] <= pos_z_i;
      ctl_q    <= controller_on_i;
      gen_q    <= route_gen_i;
      st_q     <= station_i;
      dir_q[0] <= dir_x_i;
      dir_q[1] <= dir_y_i;
      dir_q[2] <= dir_z_i;
      dirv_q   <= dir_valid_i;
    end
  end

  // deltas from the anchor as magnitude and sign
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [32:0] d;
      d = 33'(pos_q[i]) - 33'(apos_q[i]);
      dneg[i]   = d[32];
      dabs[i]   = d[32] ? 32'(-d) : d[31:0];
      dirneg[i] = adir_q[i][15];
      dirabs[i] = adir_q[i][15] ? 16'(-adir_q[i]) : adir_q[i];
    end
  end

  // the drain step after the last product selects lane 0
  assign idx   = (step_q < 5'd3) ? step_q[1:0] :
                 (step_q < 5'(pss_pkg::MUL_STEPS)) ? 2'(step_q - 5'd3) : 2'd0;
  assign mul_a = dabs[idx];
  assign mul_b = (step_q < 5'd3) ? dabs[idx] : {16'd0, dirabs[idx]};

  // shared multiplier, then accumulate in the cycle after
  always_ff @(posedge clk_i) begin
    if (state_q == pss_pkg::ST_MUL) begin
      prod_q   <= 64'(mul_a) * 64'(mul_b);
      pvalid_q <= step_q < 5'(pss_pkg::MUL_STEPS);
      pdot_q   <= step_q >= 5'd3;
      pneg_q   <= dneg[idx] ^ dirneg[idx];
    end else begin
      pvalid_q <= 1'b0;
    end
    if (accept) begin
      sum_q <= '0;
      dot_q <= '0;
    end else if (pvalid_q) begin
      if (!pdot_q) sum_q <= sum_q + 66'(prod_q);
      else if (pneg_q) dot_q <= dot_q - 52'(prod_q);
      else dot_q <= dot_q + 52'(prod_q);
    end
  end

  // restoring square root, one result bit per cycle
  assign sq_t = r_q + bit_q;
  always_ff @(posedge clk_i) begin
    if (state_q == pss_pkg::ST_MUL) begin
      n_q   <= sum_q[63:0] + ((pvalid_q && !pdot_q) ? prod_q : 64'd0);
      r_q   <= '0;
      bit_q <= 64'h4000_0000_0000_0000;
    end else if (state_q == pss_pkg::ST_SQRT) begin
      if (n_q >= sq_t) begin
        n_q <= n_q - sq_t;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  // decision
  logic        f_take, f_av, f_recov, rpa, restart, used;
  logic [7:0]  f_stalls, nst;
  logic [31:0] f_reseeds, disp, sgain, along, useful;
  logic [39:0] age;
  logic [32:0] g;
  logic [51:0] dsh;
  logic [1:0]  o_verdict;
  logic        o_req, o_rec, o_used;
  logic [7:0]  o_stall;
  logic [31:0] o_reseed, o_disp, o_sgain, o_along, o_useful;
  logic [39:0] o_age;

  assign rpa     = gen_q != 32'd0;
  assign restart = !av_q || (stamp_q <= at_q) || (rpa && (!ast_ok_q || agen_q != gen_q));
  assign age     = stamp_q - at_q;
  assign used    = rpa && ast_ok_q;
  assign disp    = (sum_q[65:64] != 2'd0) ? M32 : r_q[31:0];
  assign g       = 33'(st_q) - 33'(ast_q);
  assign sgain   = (used && !g[32] && g != 33'd0) ? g[31:0] : 32'd0;
  assign dsh     = dot_q >> pss_pkg::DIR_FRAC_BITS;
  assign along   = (!adir_ok_q || dot_q[51] || dot_q == 52'sd0) ? 32'd0 :
                   (dsh[51:32] != 20'd0) ? M32 : dsh[31:0];
  assign useful  = used ? ((sgain > along) ? sgain : along) : disp;
  assign nst     = (stalls_q == 8'hFF) ? 8'hFF : stalls_q + 8'd1;

  always_comb begin
    f_take = 1'b0; f_av = av_q; f_recov = recov_q;
    f_stalls = stalls_q; f_reseeds = reseeds_q;
    o_verdict = pss_pkg::VERDICT_INACTIVE; o_req = 1'b0; o_rec = recov_q;
    o_stall = stalls_q; o_reseed = reseeds_q; o_age = '0; o_disp = '0;
    o_used = 1'b0; o_sgain = '0; o_along = '0; o_useful = '0;
    if (clr_q) begin
      f_av = 1'b0; f_stalls = '0; f_recov = 1'b0; o_rec = 1'b0; o_stall = '0;
    end else if (!enabled_q) begin
      f_av = 1'b0; f_stalls = '0; f_recov = 1'b0; o_rec = 1'b0;
    end else if (stamp_q == 40'd0) begin
      f_av = 1'b0;
    end else if (!ctl_q) begin
      if (av_q && stamp_q > at_q && age > {7'd0, window_q, 1'b0} && !recov_q) f_av = 1'b0;
    end else if (restart) begin
      f_take = 1'b1; f_stalls = '0;
      o_verdict = pss_pkg::VERDICT_MONITORING; o_stall = '0;
    end else begin
      o_age = age; o_disp = disp; o_used = used; o_sgain = sgain; o_along = along;
      o_verdict = pss_pkg::VERDICT_MONITORING;
      if (age >= {8'd0, window_q}) begin
        o_useful = useful;
        f_take = 1'b1;
        if (useful >= min_prog_q || (used && disp >= min_move_q)) begin
          f_recov = 1'b0; f_stalls = '0;
          o_verdict = pss_pkg::VERDICT_MOVING; o_rec = 1'b0; o_stall = '0;
        end else if (nst < sbr_q) begin
          f_stalls = nst; o_stall = nst;
        end else begin
          f_reseeds = reseeds_q + 32'd1; f_recov = 1'b1; f_stalls = '0;
          o_verdict = pss_pkg::VERDICT_RESEED; o_req = 1'b1; o_rec = 1'b1;
          o_stall = '0; o_reseed = reseeds_q + 32'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      av_q <= 1'b0; at_q <= '0; agen_q <= '0; ast_q <= '0;
      ast_ok_q <= 1'b0; adir_ok_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        apos_q[i] <= '0;
        adir_q[i] <= '0;
      end
      stalls_q <= '0; recov_q <= 1'b0; reseeds_q <= '0;
    end else if (fin_fire) begin
      av_q <= f_av || f_take;
      stalls_q <= f_stalls; recov_q <= f_recov; reseeds_q <= f_reseeds;
      if (f_take) begin
        at_q <= stamp_q; agen_q <= gen_q; ast_q <= st_q;
        ast_ok_q <= rpa; adir_ok_q <= dirv_q;
        for (int i = 0; i < 3; i++) begin
          apos_q[i] <= pos_q[i];
          adir_q[i] <= dir_q[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (fin_fire) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (fin_fire) begin
      verdict_q <= o_verdict; req_q <= o_req; rec_q <= o_rec; ostall_q <= o_stall;
      oreseed_q <= o_reseed; age_q <= o_age; disp_q <= o_disp; used_q <= o_used;
      sgain_q <= o_sgain; along_q <= o_along; useful_q <= o_useful;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign verdict_o        = verdict_q;
  assign reseed_request_o = req_q;
  assign in_recovery_o    = rec_q;
  assign stall_count_o    = ostall_q;
  assign reseed_count_o   = oreseed_q;
  assign age_us_o         = age_q;
  assign displacement_o   = disp_q;
  assign route_used_o     = used_q;
  assign station_gain_o   = sgain_q;
  assign along_gain_o     = along_q;
  assign useful_gain_o    = useful_q;

endmodule

### hw/rtl/pss_checker.sv
// Port-level checks for the progress stall supervisor, bound to the top level.
`include "progress_stall_supervisor_macros.svh"

module pss_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  verdict_o,
  input logic        reseed_request_o,
  input logic        in_recovery_o,
  input logic [7:0]  stall_count_o,
  input logic [31:0] displacement_o,
  input logic [31:0] useful_gain_o,
  input logic [31:0] reseed_count_o
);

  `PSS_ASSERT_IMP(a_req_only_reseed, out_valid_o && reseed_request_o,
    verdict_o == pss_pkg::VERDICT_RESEED)
  `PSS_ASSERT_IMP(a_reseed_state, out_valid_o && verdict_o == pss_pkg::VERDICT_RESEED,
    reseed_request_o && in_recovery_o && stall_count_o == 8'd0)
  `PSS_ASSERT_IMP(a_inactive_quiet, out_valid_o && verdict_o == pss_pkg::VERDICT_INACTIVE,
    displacement_o == 32'd0 && useful_gain_o == 32'd0)
  `PSS_ASSERT_NXT(a_hold_stalled, out_valid_o && !out_ready_i,
    out_valid_o && $stable(reseed_count_o) && $stable(verdict_o))

endmodule

bind progress_stall_supervisor pss_checker u_pss_checker (.*);

### verif/tb.sv
// Testbench for the progress stall supervisor: random and directed observations checked against
// a cycle-free predictor.
`timescale 1ns / 1ps

module tb;

  localparam longint unsigned M32 = 64'hFFFF_FFFF;
  localparam int TIMEOUT_CYCLES = 1_000_000;

  typedef struct packed {
    logic              clear;
    logic [39:0]       stamp;
    logic signed [31:0] px, py, pz;
    logic              ctl;
    logic [31:0]       gen;
    logic signed [31:0] st;
    logic signed [15:0] dx, dy, dz;
    logic              dvalid;
  } obs_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic        rreq;
    logic        rec;
    logic [7:0]  stall;
    logic [31:0] rcount;
    logic [39:0] age;
    logic [31:0] disp;
    logic        used;
    logic [31:0] sgain;
    logic [31:0] along;
    logic [31:0] useful;
  } verdict_rec_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  obs_t cur = '0;

  logic cfg_ready_o, in_ready_o, out_valid_o;
  logic [1:0] verdict_o;
  logic reseed_request_o, in_recovery_o, route_used_o;
  logic [7:0] stall_count_o;
  logic [31:0] reseed_count_o, displacement_o, station_gain_o, along_gain_o, useful_gain_o;
  logic [39:0] age_us_o;

  progress_stall_supervisor uut (
    .clk_i, .rst_ni,
    .cfg_valid_i(cfg_valid), .cfg_ready_o, .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o,
    .clear_i(cur.clear), .stamp_us_i(cur.stamp),
    .pos_x_i(cur.px), .pos_y_i(cur.py), .pos_z_i(cur.pz),
    .controller_on_i(cur.ctl), .route_gen_i(cur.gen), .station_i(cur.st),
    .dir_x_i(cur.dx), .dir_y_i(cur.dy), .dir_z_i(cur.dz), .dir_valid_i(cur.dvalid),
    .out_valid_o, .out_ready_i(out_ready),
    .verdict_o, .reseed_request_o, .in_recovery_o, .stall_count_o, .reseed_count_o,
    .age_us_o, .displacement_o, .route_used_o, .station_gain_o, .along_gain_o, .useful_gain_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor copy of registers and state
  logic        en_c = 1'b1;
  logic [31:0] win_c = pss_pkg::WINDOW_RST, minp_c = pss_pkg::MIN_PROG_RST;
  logic [31:0] minm_c = pss_pkg::MIN_MOVE_RST;
  logic [7:0]  thr_c = pss_pkg::STALLS_RST;
  logic        a_valid = 1'b0, a_st_ok = 1'b0, a_dir_ok = 1'b0, recov = 1'b0;
  logic [39:0] a_time = '0;
  longint      a_pos [3];
  longint      a_dir [3];
  logic [31:0] a_gen = '0;
  longint      a_st = 0;
  logic [7:0]  stalls = '0;
  logic [31:0] reseeds = '0;

  obs_t         obs_q[$];
  verdict_rec_t verdict_q[$];
  int  errors = 0;
  int  cycles = 0;
  bit  idle_on = 1'b1;
  int  hold_tok = 0, hold_seen = 0;
  logic in_acc = 1'b0, out_acc = 1'b0, cfg_acc = 1'b0;
  int  gap_left = 0, rwait = 0, hold_left = 0;

  // generator state
  logic [39:0] g_t;
  logic signed [31:0] g_x, g_y, g_z, g_st;
  logic [31:0] g_gen;
  int unsigned win_hint = 1000;

  function automatic logic [63:0] isqrt(logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void take_anchor(obs_t o, logic rpa);
    a_valid = 1'b1;
    a_time = o.stamp;
    a_pos[0] = o.px; a_pos[1] = o.py; a_pos[2] = o.pz;
    a_dir[0] = o.dx; a_dir[1] = o.dy; a_dir[2] = o.dz;
    a_gen = o.gen;
    a_st = o.st;
    a_st_ok = rpa;
    a_dir_ok = o.dvalid;
  endfunction

  function automatic verdict_rec_t supervise(obs_t o);
    verdict_rec_t r;
    longint d [3];
    longint unsigned ab, dot_u;
    logic [65:0] sum;
    longint g, dot;
    logic rpa;
    logic [63:0] age, useful;
    r = '0;
    r.rec = recov;
    r.stall = stalls;
    r.rcount = reseeds;
    if (o.clear) begin
      a_valid = 1'b0; stalls = '0; recov = 1'b0;
      r.rec = 1'b0; r.stall = '0;
      return r;
    end
    if (!en_c) begin
      recov = 1'b0; stalls = '0; a_valid = 1'b0;
      r.rec = 1'b0;
      return r;
    end
    if (o.stamp == 0) begin
      a_valid = 1'b0;
      return r;
    end
    if (!o.ctl) begin
      if (a_valid && o.stamp > a_time &&
          64'(o.stamp - a_time) > 2 * 64'(win_c) && !recov)
        a_valid = 1'b0;
      return r;
    end
    rpa = (o.gen != 0);
    if (!a_valid || o.stamp <= a_time || (rpa && (!a_st_ok || a_gen != o.gen))) begin
      take_anchor(o, rpa);
      stalls = '0;
      r.verdict = pss_pkg::VERDICT_MONITORING;
      r.stall = '0;
      return r;
    end
    age = 64'(o.stamp - a_time);
    d[0] = longint'(o.px) - a_pos[0];
    d[1] = longint'(o.py) - a_pos[1];
    d[2] = longint'(o.pz) - a_pos[2];
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      ab = d[i] < 0 ? longint'(-d[i]) : d[i];
      sum = sum + 66'(ab) * 66'(ab);
    end
    if (sum > 66'(64'hFFFF_FFFF_FFFF_FFFF)) r.disp = '1;
    else r.disp = 32'(isqrt(sum[63:0]));
    r.used = rpa && a_st_ok;
    if (r.used) begin
      g = longint'(o.st) - a_st;
      r.sgain = g > 0 ? 32'(g) : '0;
    end
    if (a_dir_ok) begin
      dot = d[0] * a_dir[0] + d[1] * a_dir[1] + d[2] * a_dir[2];
      dot_u = longint'(dot) >>> pss_pkg::DIR_FRAC_BITS;
      r.along = dot > 0 ? (dot_u > M32 ? '1 : 32'(dot_u)) : '0;
    end
    r.age = age[39:0];
    r.verdict = pss_pkg::VERDICT_MONITORING;
    if (age < 64'(win_c)) return r;
    useful = r.used ? (r.sgain > r.along ? r.sgain : r.along) : r.disp;
    r.useful = useful[31:0];
    if (useful >= 64'(minp_c) || (r.used && r.disp >= minm_c)) begin
      recov = 1'b0; stalls = '0;
      take_anchor(o, rpa);
      r.verdict = pss_pkg::VERDICT_MOVING; r.rec = 1'b0; r.stall = '0;
      return r;
    end
    if (stalls < 8'd255) stalls = stalls + 8'd1;
    r.stall = stalls;
    take_anchor(o, rpa);
    if (stalls < thr_c) return r;
    reseeds = reseeds + 32'd1;
    recov = 1'b1;
    stalls = '0;
    r.verdict = pss_pkg::VERDICT_RESEED; r.rreq = 1'b1; r.rec = 1'b1; r.stall = '0;
    r.rcount = reseeds;
    return r;
  endfunction

  task automatic report(string field, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got %0h want %0h at cycle %0d", field, got, want, cycles);
    errors++;
  endtask

  task automatic check_result(verdict_rec_t w);
    if (verdict_o != w.verdict) report("verdict", verdict_o, w.verdict);
    if (reseed_request_o != w.rreq) report("reseed_request", reseed_request_o, w.rreq);
    if (in_recovery_o != w.rec) report("in_recovery", in_recovery_o, w.rec);
    if (stall_count_o != w.stall) report("stall_count", stall_count_o, w.stall);
    if (reseed_count_o != w.rcount) report("reseed_count", reseed_count_o, w.rcount);
    if (age_us_o != w.age) report("age_us", age_us_o, w.age);
    if (displacement_o != w.disp) report("displacement", displacement_o, w.disp);
    if (route_used_o != w.used) report("route_used", route_used_o, w.used);
    if (station_gain_o != w.sgain) report("station_gain", station_gain_o, w.sgain);
    if (along_gain_o != w.along) report("along_gain", along_gain_o, w.along);
    if (useful_gain_o != w.useful) report("useful_gain", useful_gain_o, w.useful);
  endtask

  // sampling, prediction and checking on the rising edge
  always @(posedge clk_i) begin
    in_acc <= in_valid && in_ready_o;
    out_acc <= out_valid_o && out_ready;
    cfg_acc <= cfg_valid && cfg_ready_o;
    cycles <= cycles + 1;
    if (cycles > TIMEOUT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("[progress_stall_supervisor] ERROR");
      $finish;
    end
    if (rst_ni) begin
      if (cfg_valid && cfg_ready_o) begin
        case (pss_pkg::cfg_reg_e'(cfg_index))
          pss_pkg::REG_ENABLED:  en_c = cfg_data[0];
          pss_pkg::REG_WINDOW:   win_c = cfg_data;
          pss_pkg::REG_MIN_PROG: minp_c = cfg_data;
          pss_pkg::REG_MIN_MOVE: minm_c = cfg_data;
          pss_pkg::REG_STALLS:   thr_c = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready_o) verdict_q.push_back(supervise(cur));
      if (out_valid_o && out_ready) begin
        if (verdict_q.size() == 0) begin
          $display("unexpected result at cycle %0d", cycles);
          errors++;
        end else begin
          check_result(verdict_q.pop_front());
        end
      end
    end
  end

  // input driver
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || in_acc)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (obs_q.size() > 0) begin
        cur <= obs_q.pop_front();
        in_valid <= 1'b1;
        gap_left <= idle_on ? $urandom_range(0, 6) : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver, with a single long hold-off
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_tok != hold_seen) begin
        hold_seen <= hold_tok;
        hold_left <= 500;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (out_acc && idle_on) begin
        int n;
        n = $urandom_range(0, 6);
        out_ready <= (n == 0);
        rwait <= (n == 0) ? 0 : n - 1;
      end else if (rwait > 0) begin
        rwait <= rwait - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(pss_pkg::cfg_reg_e idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(negedge clk_i); while (!cfg_acc);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (obs_q.size() > 0 || in_valid || verdict_q.size() > 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
  endtask

  task automatic setup(logic en, logic [31:0] win, logic [31:0] minp, logic [31:0] minm,
                       logic [7:0] thr);
    write_reg(pss_pkg::REG_ENABLED, {31'(0), en});
    write_reg(pss_pkg::REG_WINDOW, win);
    write_reg(pss_pkg::REG_MIN_PROG, minp);
    write_reg(pss_pkg::REG_MIN_MOVE, minm);
    write_reg(pss_pkg::REG_STALLS, {24'(0), thr});
    win_hint = (win > 5000 || win == 0) ? 5000 : win;
  endtask

  task automatic push_obs(logic clr, logic [39:0] t, logic [31:0] x, logic [31:0] y,
                          logic [31:0] z, logic ctl, logic [31:0] gen, logic [31:0] st,
                          logic [15:0] dx, logic [15:0] dy, logic [15:0] dz, logic dv);
    obs_t o;
    o = {clr, t, x, y, z, ctl, gen, st, dx, dy, dz, dv};
    obs_q.push_back(o);
  endtask

  function automatic logic signed [31:0] nudge(logic signed [31:0] v);
    case ($urandom_range(0, 4))
      0, 1: return v;
      2: return v + $signed(32'($urandom_range(0, 8192))) - 32'sd4096;
      3: return v + $signed(32'($urandom_range(0, 262144))) - 32'sd65536;
      default: return $urandom;
    endcase
  endfunction

  // mostly coherent tracks with occasional noise and broken ticks
  task automatic push_random(int n);
    obs_t o;
    int r, ax;
    logic signed [15:0] sgn;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        o.clear = 1'($urandom_range(0, 1));
        o.stamp = 40'({$urandom, $urandom});
        o.px = $urandom; o.py = $urandom; o.pz = $urandom;
        o.ctl = 1'($urandom_range(0, 1));
        o.gen = $urandom; o.st = $urandom;
        o.dx = 16'($urandom_range(0, 32768)) - 16'sd16384;
        o.dy = 16'($urandom_range(0, 32768)) - 16'sd16384;
        o.dz = 16'($urandom_range(0, 32768)) - 16'sd16384;
        o.dvalid = 1'($urandom_range(0, 1));
      end else begin
        if (r < 15) g_t = g_t - $urandom_range(0, win_hint);
        else g_t = g_t + $urandom_range(0, win_hint * 3 / 2 + 1);
        g_x = nudge(g_x); g_y = nudge(g_y); g_z = nudge(g_z);
        if ($urandom_range(0, 2) != 0) g_st = g_st + $signed(32'($urandom_range(0, 131072)));
        if ($urandom_range(0, 40) == 0) g_gen = $urandom_range(0, 3);
        o.clear = ($urandom_range(0, 60) == 0);
        o.stamp = ($urandom_range(0, 80) == 0) ? 40'd0 : g_t;
        o.px = g_x; o.py = g_y; o.pz = g_z;
        o.ctl = ($urandom_range(0, 19) != 0);
        o.gen = g_gen; o.st = g_st;
        ax = $urandom_range(0, 2);
        sgn = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
        o.dx = (ax == 0) ? sgn : 16'sd0;
        o.dy = (ax == 1) ? sgn : 16'sd0;
        o.dz = (ax == 2) ? sgn : 16'sd0;
        o.dvalid = ($urandom_range(0, 9) != 0);
      end
      obs_q.push_back(o);
    end
  endtask

  initial begin
    a_pos = '{0, 0, 0};
    a_dir = '{0, 0, 0};
    g_t = 40'd1000 + $urandom_range(0, 1 << 20);
    g_x = 0; g_y = 0; g_z = 0; g_st = 0; g_gen = 1;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed, register defaults
    push_obs(1, 40'd10, 0, 0, 0, 1, 1, 0, 0, 0, 0, 0);
    push_obs(0, 40'd0, 0, 0, 0, 1, 1, 0, 0, 0, 0, 0);
    push_obs(0, 40'd5, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0);
    push_obs(0, 40'd100, 0, 0, 0, 1, 1, 0, 16'sd16384, 0, 0, 1);
    push_obs(0, 40'd200, 32'h7FFF_FFFF, 0, 0, 1, 1, 0, 0, 0, 0, 1);
    push_obs(0, 40'd1000100, 32'h1_0000, 0, 0, 1, 1, 0, 0, 0, 0, 1);
    push_obs(0, 40'd2000200, 32'h1_0000, 0, 0, 1, 1, 0, 0, 0, 0, 1);
    push_obs(0, 40'd3000300, 32'h1_0000, 0, 0, 1, 1, 0, 0, 0, 0, 1);
    push_obs(0, 40'd9000000, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0);
    push_obs(0, 40'd9000001, 0, 0, 0, 1, 2, 0, 0, 0, 0, 0);
    push_obs(0, 40'd11000000, 32'h100, 0, 0, 1, 0, 0, 0, 0, 0, 0);
    push_obs(0, 40'd50, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0);
    push_obs(0, 40'd100, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 0, 0,
             -16'sd16384, -16'sd16384, -16'sd16384, 1);
    push_obs(0, 40'd1000100, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 0, 0,
             0, 0, 0, 0);
    push_obs(0, 40'd1000200, 0, 0, 0, 1, 5, 32'h8000_0000, 16'sd16384, 16'sd16384,
             16'sd16384, 1);
    push_obs(0, 40'd2000200, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 1, 5, 32'h7FFF_FFFF, 0, 0, 0, 1);
    push_obs(0, 40'hFF_FFFF_FFFF, 0, 0, 0, 1, 5, 0, 0, 0, 0, 1);
    push_obs(0, 40'd30000000, 0, 0, 0, 1, 5, 0, 0, 0, 0, 1);
    push_obs(0, 40'd40000000, 0, 0, 0, 0, 5, 0, 0, 0, 0, 1);
    drain();

    // zero window, reseed on first stalled window
    setup(1, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0);
    push_obs(0, 40'd100, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0);
    push_obs(0, 40'd101, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0);
    push_obs(0, 40'd102, 0, 0, 0, 1, 3, 0, 0, 0, 0, 0);
    push_obs(0, 40'd103, 0, 0, 0, 1, 3, 0, 0, 0, 0, 0);
    drain();

    // disabled
    setup(0, 32'd100, 32'd0, 32'd0, 8'd1);
    push_random(60);
    drain();

    idle_on = 1'b0;
    setup(1, 32'd1000, 32'd65536, 32'd65536, 8'd2);
    push_random(170);
    drain();
    idle_on = 1'b1;

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: setup(1, 32'd1, 32'd0, 32'd65536, 8'd1);
        1: setup(1, 32'd2000, 32'd100000, 32'd0, 8'd3);
        2: setup(1, 32'hFFFF_FFFF, 32'd65536, 32'hFFFF_FFFF, 8'd255);
        3: setup(1, 32'd500, 32'hFFFF_FFFF, 32'd200000, 8'd2);
        4: setup(1, $urandom_range(1, 4000), $urandom_range(0, 1 << 18),
                 $urandom_range(0, 1 << 18), 8'($urandom_range(1, 4)));
        5: setup(1, 32'd3000, 32'd30000, 32'd30000, 8'd1);
        default: setup(1, $urandom_range(1, 4000), $urandom, $urandom,
                       8'($urandom_range(1, 255)));
      endcase
      if (ph == 1) hold_tok = hold_tok + 1;
      push_random(120);
      // sender pause until everything has come back
      while (obs_q.size() > 0 || in_valid || verdict_q.size() > 0) @(negedge clk_i);
      push_random(120);
      drain();
    end

    drain();
    if (verdict_q.size() != 0) begin
      $display("%0d results never arrived", verdict_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("[progress_stall_supervisor] OK");
    end else begin
      $display("[progress_stall_supervisor] ERROR");
    end
    $finish;
  end

endmodule
